@@ rtl/cobsr_pkg.sv @@
// Shared types and constants for the COBS/R stream decoder.
`default_nettype none

package cobsr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CountW = 17;

  // Code byte of a full run; no zero follows such a run.
  localparam logic [ByteW-1:0]  FULL_RUN         = 8'hFF;
  // Saturation value of the decoded byte count.
  localparam logic [CountW-1:0] COUNT_MAX        = 17'h1FFFF;
  // Buffer size after reset.
  localparam logic [LenW-1:0]   MAX_LENGTH_RESET = 16'd256;

  // One result beat.
  typedef struct packed {
    logic             data_valid;
    logic [ByteW-1:0] data_byte;
    logic             packet_end;
    logic             overrun;
  } cobsr_result_t;

endpackage

`default_nettype wire

@@ rtl/cobsr_in_stage.sv @@
// Input register stage that holds one encoded byte until the decode stage takes it.
`default_nettype none

module cobsr_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        enc_valid,
  output logic                             enc_stall,
  input  wire logic [cobsr_pkg::ByteW-1:0] in_byte,
  input  wire logic                        take,
  output logic                             hold_valid,
  output logic [cobsr_pkg::ByteW-1:0]      hold_byte
);

  logic accept;

  // The stage is free when empty or when its byte moves on in this cycle.
  assign enc_stall = hold_valid && !take;
  assign accept    = enc_valid && !enc_stall;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  // Payload register, loaded on each accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cobsr_dec_core.sv @@
// Decode state, single-pass byte decode logic and the result register.
`default_nettype none

module cobsr_dec_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [cobsr_pkg::LenW-1:0]  cfg_wdata,
  input  wire logic                        hold_valid,
  input  wire logic [cobsr_pkg::ByteW-1:0] hold_byte,
  output logic                             take,
  output logic                             res_valid,
  input  wire logic                        res_stall,
  output cobsr_pkg::cobsr_result_t         res
);

  logic [cobsr_pkg::LenW-1:0]   max_length;
  logic [cobsr_pkg::ByteW-1:0]  run_left;
  logic [cobsr_pkg::ByteW-1:0]  code_byte;
  logic [cobsr_pkg::CountW-1:0] decoded_count;

  logic [cobsr_pkg::ByteW-1:0]  run_left_next;
  logic [cobsr_pkg::ByteW-1:0]  code_byte_next;
  logic [cobsr_pkg::CountW-1:0] decoded_count_next;

  logic                         run_one;
  logic                         run_more;
  logic                         byte_zero;
  logic                         do_count;
  logic                         fits;
  logic [cobsr_pkg::CountW-1:0] limit;
  logic [cobsr_pkg::CountW-1:0] count_after;
  logic                         has_result;
  cobsr_pkg::cobsr_result_t     step;

  // A held byte moves on when the result register is empty or draining.
  assign take = hold_valid && (!res_valid || !res_stall);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= cobsr_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_wdata;
    end
  end

  // Decode of one byte against the current run state.
  always_comb begin
    run_one   = (run_left == 8'd1);
    run_more  = (run_left > 8'd1);
    byte_zero = (hold_byte == '0);
    limit     = {1'b0, max_length};

    // At most one decoded byte per beat: an inserted zero at run end,
    // a copied data byte, or the code byte when a frame ends mid-run.
    do_count = (run_one && (code_byte != cobsr_pkg::FULL_RUN) && !byte_zero) || run_more;
    fits     = decoded_count < limit;

    if (do_count && (decoded_count != cobsr_pkg::COUNT_MAX)) begin
      count_after = decoded_count + 1'b1;
    end else begin
      count_after = decoded_count;
    end

    step            = '0;
    step.data_valid = do_count && fits;
    step.packet_end = byte_zero;
    step.overrun    = byte_zero && (count_after > limit);
    if (step.data_valid) begin
      priority if (run_one) begin
        step.data_byte = '0;
      end else if (byte_zero) begin
        step.data_byte = code_byte;
      end else begin
        step.data_byte = hold_byte;
      end
    end
    has_result = step.data_valid || step.packet_end;

    // Next run state: a zero ends the frame, otherwise count down the run
    // or take this byte as the next code byte.
    code_byte_next = code_byte;
    if (byte_zero) begin
      run_left_next = '0;
    end else if (run_more) begin
      run_left_next = run_left - 1'b1;
    end else begin
      run_left_next  = hold_byte;
      code_byte_next = hold_byte;
    end

    decoded_count_next = byte_zero ? '0 : count_after;
  end

  // Run state and packet length.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_left      <= '0;
      code_byte     <= '0;
      decoded_count <= '0;
    end else if (take) begin
      run_left      <= run_left_next;
      code_byte     <= code_byte_next;
      decoded_count <= decoded_count_next;
    end
  end

  // Result register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= has_result;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take && has_result) begin
      res <= step;
    end
  end

`ifndef SYNTH
  // A frame end always leaves the packet length cleared.
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (take && byte_zero) |=> (decoded_count == '0))
    else $error("decoded count not cleared after packet end");

  // The bytes left in a run never exceed the run's code byte.
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_left <= code_byte)
    else $error("run length exceeds code byte");

  // Overrun is only reported together with a packet end.
  a_overrun_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.overrun) |-> res.packet_end)
    else $error("overrun without packet end");

  // A beat without a decoded byte carries a zero data byte.
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.data_valid) |-> (res.data_byte == '0))
    else $error("data byte set without data valid");
`endif

endmodule

`default_nettype wire

@@ rtl/cobsr_stream_decoder_unit.sv @@
// COBS/R stream decoder: one encoded byte in, at most one decoded result beat out.
// Path: each accepted byte is held in the input register, then decoded into the
// result register, from which its result beat is presented. A stalled result holds
// the input register, which then stalls.
// Throughput: one byte per cycle unless the result stalls; the run state updates per byte.
// Reset (synchronous, active high): empties both registers, clears run state and
// count, and sets max_length to 256.
`default_nettype none

module cobsr_stream_decoder_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [cobsr_pkg::LenW-1:0]  cfg_wdata,
  input  wire logic                        enc_valid,
  output logic                             enc_stall,
  input  wire logic [cobsr_pkg::ByteW-1:0] in_byte,
  output logic                             res_valid,
  input  wire logic                        res_stall,
  output logic                             data_valid,
  output logic [cobsr_pkg::ByteW-1:0]      data_byte,
  output logic                             packet_end,
  output logic                             overrun
);

  logic                          hold_valid;
  logic [cobsr_pkg::ByteW-1:0]   hold_byte;
  logic                          take;
  cobsr_pkg::cobsr_result_t      res;

  // Input register.
  cobsr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .enc_valid  (enc_valid),
    .enc_stall  (enc_stall),
    .in_byte    (in_byte),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  // Decode and result register.
  cobsr_dec_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .take       (take),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  // Result fields to ports.
  assign data_valid = res.data_valid;
  assign data_byte  = res.data_byte;
  assign packet_end = res.packet_end;
  assign overrun    = res.overrun;

endmodule

`default_nettype wire

@@ test/cobsr_stream_decoder_tb.sv @@
// Self-checking testbench for the COBS/R stream decoder unit.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned StallLimit = 5000;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // Block inputs, all known from time zero.
  logic                             cfg_we    = 1'b0;
  logic [cobsr_pkg::LenW-1:0]       cfg_wdata = '0;
  logic                             enc_valid = 1'b0;
  logic [cobsr_pkg::ByteW-1:0]      in_byte   = '0;
  logic                             res_stall = 1'b0;

  // Block outputs.
  logic                             enc_stall;
  logic                             res_valid;
  logic                             data_valid;
  logic [cobsr_pkg::ByteW-1:0]      data_byte;
  logic                             packet_end;
  logic                             overrun;

  cobsr_stream_decoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .enc_valid  (enc_valid),
    .enc_stall  (enc_stall),
    .in_byte    (in_byte),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .data_valid (data_valid),
    .data_byte  (data_byte),
    .packet_end (packet_end),
    .overrun    (overrun)
  );

  // Encoded bytes waiting to be sent, and decoded beats waiting to arrive.
  logic [cobsr_pkg::ByteW-1:0] pend_bytes[$];
  cobsr_pkg::cobsr_result_t    expected_results[$];

  // Idle rates in percent for the sender and the receiver.
  int unsigned src_idle_pct = 0;
  int unsigned res_stall_pct = 0;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Decoder state as the testbench tracks it.
  logic [cobsr_pkg::ByteW-1:0]  run_remaining = '0;
  logic [cobsr_pkg::ByteW-1:0]  cur_code      = '0;
  logic [cobsr_pkg::CountW-1:0] decoded_len   = '0;
  logic [cobsr_pkg::LenW-1:0]   buf_limit     = cobsr_pkg::MAX_LENGTH_RESET;

  // Counts one decoded byte with saturation; true if it still fits the buffer.
  function automatic logic take_decoded_byte();
    logic fits;
    fits = (decoded_len < {1'b0, buf_limit});
    if (decoded_len != cobsr_pkg::COUNT_MAX)
      decoded_len = decoded_len + 1'b1;
    return fits;
  endfunction

  // Advances the tracked state by one encoded byte and queues the beat it yields.
  function automatic void predict_decode(input logic [cobsr_pkg::ByteW-1:0] c);
    cobsr_pkg::cobsr_result_t r;
    r = '0;
    // A finished run inserts a zero unless it was a full run or the frame ends.
    if (run_remaining == 8'd1) begin
      if (cur_code != cobsr_pkg::FULL_RUN && c != 8'h00) begin
        if (take_decoded_byte())
          r.data_valid = 1'b1;
        r.data_byte = 8'h00;
      end
      run_remaining = '0;
    end
    if (c == 8'h00) begin
      // A frame ending mid-run delivers the code byte itself.
      if (run_remaining != 0) begin
        if (take_decoded_byte()) begin
          r.data_valid = 1'b1;
          r.data_byte = cur_code;
        end
        run_remaining = '0;
      end
      r.packet_end = 1'b1;
      r.overrun = (decoded_len > {1'b0, buf_limit});
      decoded_len = '0;
    end else begin
      if (run_remaining > 8'd1) begin
        if (take_decoded_byte()) begin
          r.data_valid = 1'b1;
          r.data_byte = c;
        end
        run_remaining = run_remaining - 1'b1;
      end
      if (run_remaining == 0) begin
        cur_code = c;
        run_remaining = c;
      end
    end
    if (!r.data_valid)
      r.data_byte = '0;
    if (r.data_valid || r.packet_end)
      expected_results.push_back(r);
  endfunction

  // Sender: presents queued bytes, holds a stalled beat, idles at random.
  always @(posedge clk) begin : enc_driver
    logic accepted;
    accepted = !rst && enc_valid && !enc_stall;
    if (accepted) begin
      predict_decode(in_byte);
      void'(pend_bytes.pop_front());
    end
    if (rst) begin
      enc_valid <= 1'b0;
    end else if (!enc_valid || accepted) begin
      if (pend_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        enc_valid <= 1'b1;
        in_byte <= pend_bytes[0];
      end else begin
        enc_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks every accepted beat against the oldest expectation.
  always @(posedge clk) begin : res_monitor
    cobsr_pkg::cobsr_result_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: valid=%0d byte=%02h end=%0d over=%0d",
                     data_valid, data_byte, packet_end, overrun);
        end else begin
          want = expected_results.pop_front();
          if (data_valid !== want.data_valid || data_byte !== want.data_byte ||
              packet_end !== want.packet_end || overrun !== want.overrun) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected valid=%0d byte=%02h end=%0d over=%0d",
                       want.data_valid, want.data_byte, want.packet_end, want.overrun);
              $display("          got      valid=%0d byte=%02h end=%0d over=%0d",
                       data_valid, data_byte, packet_end, overrun);
            end
          end
        end
      end
      res_stall <= ($urandom_range(99) < res_stall_pct);
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (enc_valid && !enc_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Waits until all bytes are sent and all beats are in, then covers the latency.
  task automatic drain();
    while (pend_bytes.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes max_length while the block is idle.
  task automatic write_max_length(input logic [cobsr_pkg::LenW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    buf_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_bytes(input logic [cobsr_pkg::ByteW-1:0] seq[$]);
    foreach (seq[i])
      pend_bytes.push_back(seq[i]);
  endtask

  // Encodes one random packet as a COBS/R frame; a broken frame is cut short.
  task automatic push_frame(input bit broken, output int unsigned n);
    logic [cobsr_pkg::ByteW-1:0] blk[$];
    logic [cobsr_pkg::ByteW-1:0] frame[$];
    logic [cobsr_pkg::ByteW-1:0] b;
    int unsigned len;
    int unsigned sel;
    int unsigned keep;
    sel = $urandom_range(99);
    if (sel < 85)
      len = $urandom_range(12);
    else if (sel < 97)
      len = $urandom_range(40, 13);
    else
      len = $urandom_range(300, 240);
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
      if (b == 8'h00) begin
        frame.push_back(8'(blk.size() + 1));
        foreach (blk[j]) frame.push_back(blk[j]);
        blk.delete();
      end else begin
        blk.push_back(b);
        if (blk.size() == 254) begin
          frame.push_back(cobsr_pkg::FULL_RUN);
          foreach (blk[j]) frame.push_back(blk[j]);
          blk.delete();
        end
      end
    end
    // The last run moves a large final byte into the code position.
    if (blk.size() != 0 && blk[$] > 8'(blk.size() + 1)) begin
      frame.push_back(blk[$]);
      void'(blk.pop_back());
    end else begin
      frame.push_back(8'(blk.size() + 1));
    end
    foreach (blk[j]) frame.push_back(blk[j]);
    frame.push_back(8'h00);
    keep = broken ? $urandom_range(frame.size() - 1, 1) : frame.size();
    for (int i = 0; i < keep; i++)
      pend_bytes.push_back(frame[i]);
    n = keep;
  endtask

  // Mostly well-formed frames, some cut short, some raw noise.
  task automatic add_traffic(input int unsigned target);
    int unsigned pushed;
    int unsigned n;
    int unsigned sel;
    pushed = 0;
    while (pushed < target) begin
      sel = $urandom_range(99);
      if (sel < 78) begin
        push_frame(1'b0, n);
      end else if (sel < 90) begin
        push_frame(1'b1, n);
      end else begin
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
          pend_bytes.push_back(($urandom_range(9) < 3) ? 8'h00 : 8'($urandom_range(255)));
      end
      pushed += n;
    end
  endtask

  // Picks a buffer size, mostly small so that overruns are frequent.
  function automatic logic [cobsr_pkg::LenW-1:0] pick_max_length();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50)
      return cobsr_pkg::LenW'($urandom_range(16, 1));
    else if (sel < 85)
      return cobsr_pkg::LenW'($urandom_range(300, 17));
    else
      return cobsr_pkg::LenW'($urandom_range(65535));
  endfunction

  // Stimulus sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at the reset buffer size: empty frame, zero insertion,
    // frame end at run end, frame end mid-run, and a one-byte code.
    push_bytes('{8'h00});
    push_bytes('{8'h02, 8'h41, 8'h03, 8'h42, 8'hFF, 8'h00});
    push_bytes('{8'h05, 8'hAA, 8'hFE, 8'h00});
    push_bytes('{8'h01, 8'h01, 8'h00});
    drain();

    // Overrun with a one-byte buffer.
    write_max_length(16'd1);
    push_bytes('{8'h03, 8'h10, 8'h20, 8'h00});
    drain();

    // Zero buffer size suppresses every data byte; an empty frame still has no overrun.
    write_max_length(16'd0);
    push_bytes('{8'h02, 8'h55, 8'h00, 8'h00});
    drain();

    // Largest buffer; a full-run code ended mid-run by the frame delimiter.
    write_max_length(16'hFFFF);
    push_bytes('{8'hFF, 8'h01, 8'h00});
    drain();

    // Random traffic under each idling pattern.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  res_stall_pct = 0;  end
        1: begin src_idle_pct = 73; res_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  res_stall_pct = 73; end
        3: begin src_idle_pct = 9;  res_stall_pct = 9;  end
        default: begin src_idle_pct = 0; res_stall_pct = 0; end
      endcase
      write_max_length(pick_max_length());
      add_traffic(75);
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ cobsr_stream_decoder_unit.f @@
rtl/cobsr_pkg.sv
rtl/cobsr_in_stage.sv
rtl/cobsr_dec_core.sv
rtl/cobsr_stream_decoder_unit.sv
test/cobsr_stream_decoder_tb.sv
